>>> hdl/mp2_pkg.sv
// mp2_pkg: shared constants for the 2x2 max pooling block with argmax
// no dependencies; imported by every module of the block
package mp2_pkg;

  // default sizes handed down from the top level
  localparam int MAX_WIDTH_DEF   = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  // plane height limits and row index width
  localparam int MAX_HEIGHT = 1024;
  localparam int ROW_W      = 10;

  // configuration register widths, reset values and indexes
  localparam int CFG_WIDTH_BITS  = 7;
  localparam int CFG_HEIGHT_BITS = 11;
  localparam logic [CFG_WIDTH_BITS-1:0]  WIDTH_RST  = CFG_WIDTH_BITS'(28);
  localparam logic [CFG_HEIGHT_BITS-1:0] HEIGHT_RST = CFG_HEIGHT_BITS'(28);
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // apb address and data widths
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // entries of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

endpackage

>>> hdl/mp2_in_if.sv
// mp2_in_if: valid/ready channel carrying one input sample
// no dependencies
interface mp2_in_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

>>> hdl/mp2_out_if.sv
// mp2_out_if: valid/ready channel carrying one pooled result
// no dependencies; column width follows the largest plane width
interface mp2_out_if #(
  parameter int SAMPLE_BITS = 16,
  parameter int MAX_WIDTH   = 64
);
  localparam int CLOG_W = $clog2(MAX_WIDTH);
  localparam int COL_W  = (CLOG_W < 2) ? 2 : CLOG_W;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] pooled_value;
  logic [9:0]                    source_row;
  logic [COL_W-1:0]              source_col;
  logic                          plane_end;

  modport source (output valid, output pooled_value, output source_row,
                  output source_col, output plane_end, input ready);
  modport sink   (input valid, input pooled_value, input source_row,
                  input source_col, input plane_end, output ready);
endinterface

>>> hdl/mp2_queue.sv
// mp2_queue: small register queue between the front and back parts
// depends on mp2_pkg
module mp2_queue
  import mp2_pkg::*;
#(
  parameter int  DEPTH = QUEUE_DEPTH,
  parameter type T     = logic
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  T     data_i,
  output logic full_o,
  output logic valid_o,
  input  logic pop_i,
  output T     data_o
);
  localparam int PTR_W = (DEPTH < 2) ? 1 : $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  T                 slots_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= data_i;
    end
  end

  // fill level tracks push and pop
  a_fill_up : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |=> count_q == $past(count_q) + 1'b1)
    else $error("queue count did not rise on push");
  a_fill_down : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !push_i && pop_i |=> count_q == $past(count_q) - 1'b1)
    else $error("queue count did not fall on pop");

endmodule

>>> hdl/mp2_front.sv
// mp2_front: takes samples, tracks plane position, classifies each sample
// depends on mp2_pkg and mp2_in_if
module mp2_front
  import mp2_pkg::*;
#(
  parameter int  MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int  SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter type cmd_t       = logic
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  mp2_in_if.sink                     in_if,
  input  logic [CFG_WIDTH_BITS-1:0]  image_width_i,
  input  logic [CFG_HEIGHT_BITS-1:0] image_height_i,
  input  logic                       q_full_i,
  output logic                       push_o,
  output cmd_t                       cmd_o
);
  localparam int CLOG_W = $clog2(MAX_WIDTH);
  localparam int COL_W  = (CLOG_W < 2) ? 2 : CLOG_W;
  localparam int CW_W   = (CFG_WIDTH_BITS > COL_W + 1) ? CFG_WIDTH_BITS : COL_W + 1;
  localparam int HW     = CFG_HEIGHT_BITS;

  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [CW_W-1:0]  w_cfg, w_eff, w_even, col_x, col_nx;
  logic [HW-1:0]    h_eff, h_even, row_x, row_nx;
  logic             col_end, row_end, in_pairs, fire;

  // clamp sizes into the supported range
  always_comb begin
    w_cfg = CW_W'(image_width_i);
    if (w_cfg < CW_W'(2)) begin
      w_eff = CW_W'(2);
    end else if (w_cfg > CW_W'(MAX_WIDTH)) begin
      w_eff = CW_W'(MAX_WIDTH);
    end else begin
      w_eff = w_cfg;
    end
    if (image_height_i < HW'(2)) begin
      h_eff = HW'(2);
    end else if (image_height_i > HW'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = image_height_i;
    end
  end

  assign w_even   = {w_eff[CW_W-1:1], 1'b0};
  assign h_even   = {h_eff[HW-1:1], 1'b0};
  assign col_x    = CW_W'(col_q);
  assign col_nx   = col_x + 1'b1;
  assign row_x    = HW'(row_q);
  assign row_nx   = row_x + 1'b1;
  assign col_end  = (col_nx >= w_eff);
  assign row_end  = (row_nx >= h_eff);
  assign in_pairs = (col_x < w_even);

  assign in_if.ready = !q_full_i;
  assign fire        = in_if.valid && in_if.ready;
  assign push_o      = fire;

  always_comb begin
    cmd_o.sample  = in_if.sample;
    cmd_o.odd_col = col_q[0];
    cmd_o.odd_row = row_q[0];
    cmd_o.slot    = col_q[COL_W-1:1];
    cmd_o.row_hi  = row_q[ROW_W-1:1];
    cmd_o.col_hi  = col_q[COL_W-1:1];
    cmd_o.store   = col_q[0] && in_pairs && !row_q[0];
    cmd_o.emit    = col_q[0] && in_pairs && row_q[0] && (row_x < h_even);
    cmd_o.last    = (row_nx >= h_even) && (col_nx >= w_even);
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (fire) begin
      if (col_end) begin
        col_d = '0;
        row_d = row_end ? '0 : row_nx[ROW_W-1:0];
      end else begin
        col_d = col_nx[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

>>> hdl/mp2_back.sv
// mp2_back: line store read stage, window compare and result register
// depends on mp2_pkg and mp2_out_if
module mp2_back
  import mp2_pkg::*;
#(
  parameter int  MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int  SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter type cmd_t       = logic
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  cmd_t       q_cmd_i,
  output logic       q_pop_o,
  mp2_out_if.source  out_if
);
  localparam int LINE_DEPTH = (MAX_WIDTH / 2 < 1) ? 1 : MAX_WIDTH / 2;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          row_off;
    logic                          col_off;
  } best_t;

  best_t line_mem [LINE_DEPTH];
  best_t rd_q, pb_q, best_d;
  cmd_t  s1_q;
  logic  s1_v_q, s1_v_d, s1_load, exec_fire, wr_en, fwd, out_v_q, out_v_d;

  assign exec_fire = s1_v_q && (!s1_q.emit || !out_v_q || out_if.ready);
  assign s1_load   = q_valid_i && (!s1_v_q || exec_fire);
  assign s1_v_d    = s1_load || (s1_v_q && !exec_fire);
  assign q_pop_o   = s1_load;
  assign wr_en     = exec_fire && s1_q.store;
  // a top-pair write and a read of the same slot meet when rows are short
  assign fwd       = wr_en && (s1_q.slot == q_cmd_i.slot);

  // strict greater-than keeps the first maximum in scan order
  always_comb begin
    best_d = pb_q;
    if (!s1_q.odd_col) begin
      if (!s1_q.odd_row) begin
        best_d.value   = s1_q.sample;
        best_d.row_off = 1'b0;
        best_d.col_off = 1'b0;
      end else if ($signed(s1_q.sample) > $signed(rd_q.value)) begin
        best_d.value   = s1_q.sample;
        best_d.row_off = 1'b1;
        best_d.col_off = 1'b0;
      end else begin
        best_d = rd_q;
      end
    end else if ($signed(s1_q.sample) > $signed(pb_q.value)) begin
      best_d.value   = s1_q.sample;
      best_d.row_off = s1_q.odd_row;
      best_d.col_off = 1'b1;
    end
  end

  always_comb begin
    out_v_d = out_v_q;
    if (exec_fire && s1_q.emit) begin
      out_v_d = 1'b1;
    end else if (out_if.ready) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      pb_q    <= '0;
    end else begin
      s1_v_q  <= s1_v_d;
      out_v_q <= out_v_d;
      if (exec_fire) begin
        pb_q <= best_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_q <= q_cmd_i;
    end
    if (exec_fire && s1_q.emit) begin
      out_if.pooled_value <= best_d.value;
      out_if.source_row   <= {s1_q.row_hi, best_d.row_off};
      out_if.source_col   <= {s1_q.col_hi, best_d.col_off};
      out_if.plane_end    <= s1_q.last;
    end
  end

  // line store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      line_mem[s1_q.slot] <= best_d;
    end
    if (s1_load) begin
      rd_q <= fwd ? best_d : line_mem[q_cmd_i.slot];
    end
  end

  assign out_if.valid = out_v_q;

  a_fwd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en && s1_load && (s1_q.slot == q_cmd_i.slot) |=> rd_q == $past(best_d))
    else $error("line store bypass lost the pair just written");
  a_left_col : assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_fire && !s1_q.odd_col && !s1_q.odd_row |=> !pb_q.col_off && !pb_q.row_off)
    else $error("top-left sample of a window carries a nonzero offset");

endmodule

>>> hdl/max_pool_2x2_argmax.sv
// max_pool_2x2_argmax: top level of streaming 2x2 stride-2 max pooling
// depends on mp2_pkg, mp2_in_if, mp2_out_if, mp2_front, mp2_queue, mp2_back
//
//  channel   dir  handshake            payload
//  in_if     in   valid/ready          sample
//  out_if    out  valid/ready          pooled_value, source_row, source_col, plane_end
//  apb       in   psel/penable/pready  paddr, pwdata, prdata
//
// one sample per cycle sustained while results are taken; after its bottom-right
//   sample is taken, a result passes the queue, line store read and result register
// the line store read stage sets the rate: one registered read per sample
// reset clears counters, pair best, queue and valid flags; no clearing pass
// a stalled result stalls the back part only; the two-entry queue keeps
//   input requests flowing until it fills
module max_pool_2x2_argmax
  import mp2_pkg::*;
#(
  parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  mp2_in_if.sink             in_if,
  mp2_out_if.source          out_if,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);
  localparam int CLOG_W = $clog2(MAX_WIDTH);
  localparam int COL_W  = (CLOG_W < 2) ? 2 : CLOG_W;
  localparam int SLOT_W = COL_W - 1;

  // one classified request between front and back
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          odd_col;
    logic                          odd_row;
    logic [SLOT_W-1:0]             slot;
    logic [ROW_W-2:0]              row_hi;
    logic [COL_W-2:0]              col_hi;
    logic                          store;   // top pair done, write line store
    logic                          emit;    // window done, give a result
    logic                          last;    // last window of the plane
  } cmd_t;

  logic [CFG_WIDTH_BITS-1:0]  width_q;
  logic [CFG_HEIGHT_BITS-1:0] height_q;
  logic                       apb_wr;
  logic                       q_full, q_push, q_valid, q_pop;
  cmd_t                       front_cmd, q_cmd;

  // configuration registers, 4-byte stride, written in the access phase
  assign pready = 1'b1;
  assign apb_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (apb_wr) begin
      unique case (paddr[2])
        REG_IMAGE_WIDTH:  width_q  <= pwdata[CFG_WIDTH_BITS-1:0];
        REG_IMAGE_HEIGHT: height_q <= pwdata[CFG_HEIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_IMAGE_WIDTH:  prdata = PDATA_W'(width_q);
      REG_IMAGE_HEIGHT: prdata = PDATA_W'(height_q);
      default:          prdata = '0;
    endcase
  end

  // front: plane position and sample classification
  mp2_front #(
    .MAX_WIDTH   (MAX_WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS),
    .cmd_t       (cmd_t)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_if          (in_if),
    .image_width_i  (width_q),
    .image_height_i (height_q),
    .q_full_i       (q_full),
    .push_o         (q_push),
    .cmd_o          (front_cmd)
  );

  // decouples input requests from result stalls
  mp2_queue #(
    .DEPTH (QUEUE_DEPTH),
    .T     (cmd_t)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (front_cmd),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .data_o  (q_cmd)
  );

  // back: line store, running window best and result register
  mp2_back #(
    .MAX_WIDTH   (MAX_WIDTH),
    .SAMPLE_BITS (SAMPLE_BITS),
    .cmd_t       (cmd_t)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_cmd_i   (q_cmd),
    .q_pop_o   (q_pop),
    .out_if    (out_if)
  );

endmodule

>>> verif/tb_max_pool_2x2_argmax.sv
`timescale 1ns / 1ps
// tb_max_pool_2x2_argmax: self-checking testbench for the 2x2 max pooling block with argmax
// depends on mp2_pkg, mp2_in_if, mp2_out_if and the max_pool_2x2_argmax top level
module tb_max_pool_2x2_argmax;
  import mp2_pkg::*;

  localparam int SB          = SAMPLE_BITS_DEF;
  localparam int COL_W       = $clog2(MAX_WIDTH_DEF);
  localparam int LINE_SLOTS  = MAX_WIDTH_DEF / 2;
  // margin after the last predicted window; it covers a request that gives no result
  localparam int DRAIN_CYCLES  = 8;
  localparam int RANDOM_ITEMS  = 850;
  localparam int MAX_REPORTS   = 10;

  // one pooled window as it leaves the block
  typedef struct packed {
    logic signed [SB-1:0] value;
    logic [ROW_W-1:0]     row;
    logic [COL_W-1:0]     col;
    logic                 plane_end;
  } pooled_t;

  // best sample of a window part with its offsets inside the window
  typedef struct packed {
    logic signed [SB-1:0] value;
    logic                 row_off;
    logic                 col_off;
  } best_t;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  mp2_in_if  #(.SAMPLE_BITS(SB)) in_if ();
  mp2_out_if #(.SAMPLE_BITS(SB), .MAX_WIDTH(MAX_WIDTH_DEF)) out_if ();

  max_pool_2x2_argmax #(
    .MAX_WIDTH  (MAX_WIDTH_DEF),
    .SAMPLE_BITS(SB)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // predictor copy of the size registers and the block state
  logic [CFG_WIDTH_BITS-1:0]  cfg_width;
  logic [CFG_HEIGHT_BITS-1:0] cfg_height;
  logic [COL_W-1:0]           col_cnt;
  logic [ROW_W-1:0]           row_cnt;
  best_t                      pair_best;
  best_t                      top_pair_store [LINE_SLOTS];

  // windows predicted but not yet seen on the output
  pooled_t pending_windows [$];
  pooled_t got_window;
  pooled_t exp_window;

  int unsigned err_cnt;
  int unsigned sent_cnt;
  int unsigned hold_cycles;  // long result hold-off, served by the ready process
  bit          no_idle;      // both sides run without gaps while set

  // clock, 8 ns period
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // hard limit on the run
  initial begin
    #(5_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // sizes as the block sees them after clamping
  function automatic int unsigned eff_width();
    if (cfg_width < 2) return 2;
    if (cfg_width > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return cfg_width;
  endfunction

  function automatic int unsigned eff_height();
    if (cfg_height < 2) return 2;
    if (cfg_height > MAX_HEIGHT) return MAX_HEIGHT;
    return cfg_height;
  endfunction

  // advance the pooling state by one accepted sample, queue a finished window
  function automatic void pool_sample(input logic signed [SB-1:0] s);
    int unsigned w, h, c, r, slot;
    bit          odd_col, odd_row, in_pairs;
    pooled_t     res;
    w        = eff_width();
    h        = eff_height();
    c        = col_cnt;
    r        = row_cnt;
    slot     = (c >> 1) % LINE_SLOTS;
    odd_col  = (c & 1) != 0;
    odd_row  = (r & 1) != 0;
    in_pairs = c < (w & ~32'd1);

    if (!odd_col) begin
      if (!odd_row) begin
        // top-left opens the window
        pair_best = '{value: s, row_off: 1'b0, col_off: 1'b0};
      end else begin
        // bottom-left competes with the stored top pair
        pair_best = top_pair_store[slot];
        if (s > $signed(pair_best.value)) begin
          pair_best = '{value: s, row_off: 1'b1, col_off: 1'b0};
        end
      end
    end else begin
      if (s > $signed(pair_best.value)) begin
        pair_best = '{value: s, row_off: odd_row, col_off: 1'b1};
      end
      if (in_pairs) begin
        if (!odd_row) begin
          top_pair_store[slot] = pair_best;
        end else if (r < (h & ~32'd1)) begin
          res.value     = pair_best.value;
          res.row       = ROW_W'((r - 1) + pair_best.row_off);
          res.col       = COL_W'((c - 1) + pair_best.col_off);
          res.plane_end = (r + 1 >= (h & ~32'd1)) && (c + 1 >= (w & ~32'd1));
          pending_windows = {pending_windows, res};
        end
      end
    end

    if (c + 1 >= w) begin
      col_cnt = '0;
      row_cnt = (r + 1 >= h) ? '0 : ROW_W'(r + 1);
    end else begin
      col_cnt = COL_W'(c + 1);
    end
  endfunction

  // prediction on accepted input requests, checking on accepted result requests;
  // one process so that prediction always runs before checking
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        pool_sample(in_if.sample);
      end
      if (out_if.valid && out_if.ready) begin
        got_window = '{value: out_if.pooled_value, row: out_if.source_row,
                       col: out_if.source_col, plane_end: out_if.plane_end};
        if (pending_windows.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS) begin
            $display("[%0t] unexpected result: value %0d row %0d col %0d end %0b",
                     $realtime, got_window.value, got_window.row, got_window.col,
                     got_window.plane_end);
          end
        end else begin
          exp_window = pending_windows.pop_front();
          if (got_window.value !== exp_window.value || got_window.row !== exp_window.row ||
              got_window.col !== exp_window.col ||
              got_window.plane_end !== exp_window.plane_end) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS) begin
              $display("[%0t] mismatch: exp %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                       $realtime, exp_window.value, exp_window.row, exp_window.col,
                       exp_window.plane_end, got_window.value, got_window.row,
                       got_window.col, got_window.plane_end);
            end
          end
        end
      end
    end
  end

  // result side ready: random gaps, or one long hold-off when asked
  initial begin
    int unsigned gap;
    out_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_cycles != 0) begin
        out_if.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end else begin
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap != 0) begin
          out_if.ready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_if.valid) @(posedge clk_i);
    end
  end

  // one apb write: setup cycle, then access cycle until pready
  task automatic write_size_reg(input logic reg_idx, input int unsigned value);
    logic [PDATA_W-1:0] data;
    // junk above the register width must be dropped by the block
    data = ($urandom & ~32'h7ff) | (value & 32'h7ff);
    if (reg_idx == REG_IMAGE_WIDTH) begin
      data = ($urandom & ~32'h7f) | (value & 32'h7f);
    end
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({reg_idx, 2'b00});
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_idx == REG_IMAGE_WIDTH) begin
      cfg_width = data[CFG_WIDTH_BITS-1:0];
    end else begin
      cfg_height = data[CFG_HEIGHT_BITS-1:0];
    end
  endtask

  task automatic set_size(input int unsigned w, input int unsigned h);
    write_size_reg(REG_IMAGE_WIDTH, w);
    write_size_reg(REG_IMAGE_HEIGHT, h);
  endtask

  // offer one input request and hold it until the block takes it
  task automatic send_request(input logic signed [SB-1:0] s);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid  <= 1'b1;
    in_if.sample <= s;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sent_cnt++;
  endtask

  // stop offering, let every predicted window arrive, then let the pipe settle
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pending_windows.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // random sample, biased to extremes and to a tiny set that forces ties
  function automatic logic signed [SB-1:0] draw_sample();
    case ($urandom_range(0, 7))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2, 3:    return SB'($urandom_range(0, 3));
      default: return SB'($urandom);
    endcase
  endfunction

  // one whole plane of random samples at the current size
  task automatic run_plane();
    int unsigned n;
    n = eff_width() * eff_height();
    repeat (n) send_request(draw_sample());
    wait_idle();
  endtask

  // max in each window position, full-scale values, ties kept by first in scan order,
  // then an odd plane where the last row and column are dropped
  task automatic test_directed_windows();
    logic signed [SB-1:0] even_plane [16];
    logic signed [SB-1:0] odd_plane [9];
    even_plane = '{16'sd7, 16'sd7, -16'sd32768, 16'sd32767,
                   16'sd7, 16'sd7, -16'sd32768, -16'sd32768,
                   -16'sd5, -16'sd6, 16'sd0, 16'sd1,
                   16'sd100, 16'sd100, 16'sd1, 16'sd2};
    odd_plane  = '{-16'sd1, 16'sd0, 16'sd32767,
                   -16'sd2, -16'sd1, 16'sd5,
                   16'sd9, 16'sd9, 16'sd9};
    set_size(4, 4);
    foreach (even_plane[i]) send_request(even_plane[i]);
    wait_idle();
    set_size(3, 3);
    foreach (odd_plane[i]) send_request(odd_plane[i]);
    wait_idle();
  endtask

  // register extremes, out-of-range values clamp to the legal sizes
  task automatic test_size_extremes();
    int unsigned widths [8];
    int unsigned heights [8];
    widths  = '{64, 127, 0, 1, 65, 63, 2, 2};
    heights = '{2, 3, 1, 0, 2, 3, 3, 2};
    foreach (widths[i]) begin
      set_size(widths[i], heights[i]);
      run_plane();
    end
  endtask

  // random plane sizes with random content, some planes at full rate
  task automatic test_random_planes();
    int unsigned start_cnt;
    int unsigned w, h;
    start_cnt = sent_cnt;
    set_size(28, 28);
    run_plane();
    while (sent_cnt - start_cnt < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       w = $urandom_range(0, 1);
        1:       w = $urandom_range(65, 127);
        2:       w = 64;
        default: w = $urandom_range(2, 20);
      endcase
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 8);
      set_size(w, h);
      no_idle = ($urandom_range(0, 3) == 0);
      run_plane();
      no_idle = 1'b0;
    end
  endtask

  // results held off for a long stretch while input requests keep coming,
  // so the block fills and must stall its input
  task automatic test_result_backpressure();
    set_size(16, 4);
    no_idle     = 1'b1;
    hold_cycles = 60;
    run_plane();
    no_idle = 1'b0;
  endtask

  initial begin
    rst_ni       <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.sample <= '0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    err_cnt      = 0;
    sent_cnt     = 0;
    hold_cycles  = 0;
    no_idle      = 1'b0;
    cfg_width    = WIDTH_RST;
    cfg_height   = HEIGHT_RST;
    col_cnt      = '0;
    row_cnt      = '0;
    pair_best    = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_windows();
    test_size_extremes();
    test_random_planes();
    test_result_backpressure();

    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
